FILE: design/ttps_pkg.sv
// Shared constants for the three-track phrase step sequencer core.
// Holds sizes, register indexes and request codes; no dependencies.
`default_nettype none
package ttps_pkg;

  localparam int unsigned TRACKS  = 3;
  localparam int unsigned STEPS   = 16;
  localparam int unsigned PHRASES = 8;

  localparam int unsigned TRK_W = 2;
  localparam int unsigned STP_W = $clog2(STEPS);
  localparam int unsigned PHR_W = $clog2(PHRASES);
  localparam int unsigned MEM_DEPTH = TRACKS * PHRASES * STEPS;
  localparam int unsigned MEM_AW = TRK_W + PHR_W + STP_W;
  localparam int unsigned LIM_AW = TRK_W + PHR_W;

  localparam logic [5:0]  MAX_NOTE  = 6'd36;
  localparam logic [15:0] GLIDE_MAX = 16'd32768;
  localparam logic [12:0] GATE_MAX  = 13'd4096;

  localparam logic [2:0] REG_PAUSE  = 3'd0;
  localparam logic [2:0] REG_OCTAVE = 3'd1;
  localparam logic [2:0] REG_GLIDE0 = 3'd2;
  localparam logic [2:0] REG_GLIDE1 = 3'd3;
  localparam logic [2:0] REG_GLIDE2 = 3'd4;
  localparam logic [2:0] REG_GATE   = 3'd5;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_STEP  = 2'd1;
  localparam logic [1:0] REQ_LIMIT = 2'd2;

endpackage
`default_nettype wire

FILE: design/three_track_phrase_step_sequencer_core.sv
// Top level of the three-track phrase step sequencer: stream ports, APB
// registers, step-table memory and the per-track sequencing engine.
// Depends on ttps_pkg.
//
// channel   | direction | contents
// s_axis    | in        | tuser: req_type; tdata: write fields and tick edges
// m_axis    | out       | tdata: track, gate, pitch, step, phrase; tlast: last
// apb       | in/out    | six configuration registers at 4*i
//
// A write request completes in its accept cycle. A tick is taken only in idle;
// then each track in turn passes through evaluate, up to two step-table reads,
// the gate update, a 16-bit bit-serial glide divider while a glide runs, two
// multiply states and the output state.
// After reset a clearing pass zeroes all 384 step-table entries before the
// first beat is taken. The engine waits in its output state while the
// result register is full and not taken.
`default_nettype none
module three_track_phrase_step_sequencer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] track, [4:2] phrase_index, [8:5] pattern_index, [14:9] note_value,
  // [15] trig_off, [19:16] step_count, [22:20] phrase_count,
  // [25:23] step_edges, [28:26] clock_connected, [31:29] phrase_edges,
  // [33:32] global_edges, [39:34] zero
  input  wire logic [39:0] s_axis_tdata,
  // [1:0] req_type
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] out_track, [2] gate, [17:3] pitch, [21:18] step_position,
  // [24:22] phrase_position, [31:25] zero
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ttps_pkg::*;

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_EVAL = 4'd2;
  localparam logic [3:0] ST_RD1  = 4'd3;
  localparam logic [3:0] ST_RD2  = 4'd4;
  localparam logic [3:0] ST_GATE = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_MUL1 = 4'd7;
  localparam logic [3:0] ST_MUL2 = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  logic [2:0]  pause_q;
  logic [5:0]  octave_q;
  logic [15:0] glen_q [3];
  logic [12:0] gatelen_q;

  logic [6:0]  mem [MEM_DEPTH];
  logic [6:0]  rd_q;
  logic        mem_we;
  logic [MEM_AW-1:0] mem_waddr;
  logic [6:0]  mem_wdata;
  logic        mem_re;
  logic [MEM_AW-1:0] mem_raddr;

  logic [STP_W-1:0] slim_q [TRACKS*PHRASES];
  logic [PHR_W-1:0] plim_q [TRACKS];
  logic [STP_W-1:0] cstep_q [TRACKS];
  logic [PHR_W-1:0] cphr_q [TRACKS];
  logic             pendv_q [TRACKS];
  logic [PHR_W-1:0] pendp_q [TRACKS];
  logic [14:0] gstart_q [TRACKS];
  logic [14:0] gend_q [TRACKS];
  logic        lpv_q [TRACKS];
  logic [15:0] grem_q [TRACKS];
  logic [11:0] gaterem_q [TRACKS];
  logic        rstpend_q;
  logic        usedrst_q;

  logic [3:0]  state_q;
  logic [8:0]  clr_q;
  logic [TRK_W-1:0] trk_q;
  logic [2:0]  sedge_q, conn_q, pedge_q;
  logic        gphr_q;
  logic        take_q;
  logic        trig_q;
  logic [15:0] divr_q;
  logic [15:0] divlen_q;
  logic [15:0] q_q;
  logic [4:0]  dcnt_q;
  logic [31:0] p1_q;
  logic [30:0] p2_q;

  logic        ovalid_q;
  logic [31:0] odata_q;
  logic        olast_q;

  // Per-track combinational views.
  logic [LIM_AW-1:0] lim_idx;
  logic        t_paused, t_clk, t_sed, t_ped;
  logic [PHR_W-1:0] nxt_phr;
  logic [STP_W-1:0] nxt_step;
  logic [5:0]  note;
  logic [1:0]  oct;
  logic [6:0]  semis;
  logic [14:0] target;
  logic [15:0] glen_t;
  logic [12:0] gl;
  logic [12:0] gate_load;
  logic [15:0] grem_dec;
  logic [16:0] div_sh;
  logic [32:0] psum;
  logic        in_acc, cfg_wr, out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free = !ovalid_q || m_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;
  assign m_axis_tlast = olast_q;

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_PAUSE:  prdata = {29'd0, pause_q};
      REG_OCTAVE: prdata = {26'd0, octave_q};
      REG_GLIDE0: prdata = {16'd0, glen_q[0]};
      REG_GLIDE1: prdata = {16'd0, glen_q[1]};
      REG_GLIDE2: prdata = {16'd0, glen_q[2]};
      REG_GATE:   prdata = {19'd0, gatelen_q};
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    lim_idx  = {trk_q, cphr_q[trk_q]};
    t_paused = pause_q[trk_q];
    t_clk    = conn_q[trk_q];
    t_sed    = sedge_q[trk_q];
    t_ped    = pedge_q[trk_q];
    nxt_phr  = cphr_q[trk_q] + 1'b1;
    if (nxt_phr > plim_q[trk_q]) begin
      nxt_phr = '0;
    end
    if (rstpend_q || cstep_q[trk_q] >= slim_q[lim_idx]) begin
      nxt_step = '0;
    end else begin
      nxt_step = cstep_q[trk_q] + 1'b1;
    end
    note = rd_q[5:0];
    if (note > MAX_NOTE) begin
      note = '0;
    end
    oct    = octave_q[{trk_q, 1'b0} +: 2];
    semis  = {1'b0, note} + 7'(oct) * 7'd12;
    target = {semis, 8'd0};
    glen_t = glen_q[trk_q];
    if (glen_t == 16'd0) begin
      glen_t = 16'd1;
    end else if (glen_t > GLIDE_MAX) begin
      glen_t = GLIDE_MAX;
    end
    gl = gatelen_q;
    if (gl == 13'd0) begin
      gl = 13'd1;
    end else if (gl > GATE_MAX) begin
      gl = GATE_MAX;
    end
    gate_load = {1'b0, gaterem_q[trk_q]};
    if (trig_q && gate_load < gl) begin
      gate_load = gl;
    end
    grem_dec = (grem_q[trk_q] != 16'd0) ? grem_q[trk_q] - 16'd1 : 16'd0;
    div_sh = {divr_q, 1'b0};
    psum = {1'b0, p1_q} + {2'b0, p2_q} + 33'd32768;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    if (state_q == ST_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q[MEM_AW-1:0];
    end else if (in_acc && s_axis_tuser == REQ_STEP && s_axis_tdata[1:0] < 2'(TRACKS)) begin
      mem_we    = 1'b1;
      mem_waddr = {s_axis_tdata[1:0], s_axis_tdata[4:2], s_axis_tdata[8:5]};
      mem_wdata = {s_axis_tdata[15], s_axis_tdata[14:9]};
    end
    if (state_q == ST_EVAL) begin
      if (t_clk && !t_paused) begin
        mem_re    = t_sed;
        mem_raddr = {trk_q, cphr_q[trk_q], nxt_step};
      end else begin
        mem_re    = pendv_q[trk_q] && (pendp_q[trk_q] != cphr_q[trk_q]);
        mem_raddr = {trk_q, pendp_q[trk_q], cstep_q[trk_q]};
      end
    end else if (state_q == ST_RD1) begin
      mem_re    = take_q && pendv_q[trk_q] && (pendp_q[trk_q] != cphr_q[trk_q]);
      mem_raddr = {trk_q, pendp_q[trk_q], cstep_q[trk_q]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_GATE) begin
      divr_q   <= grem_dec;
      divlen_q <= glen_t;
    end else if (state_q == ST_DIV) begin
      divr_q <= (div_sh >= {1'b0, divlen_q}) ? 16'(div_sh - {1'b0, divlen_q})
                                            : div_sh[15:0];
    end
    if (state_q == ST_MUL1) begin
      p1_q <= gend_q[trk_q] * (17'h10000 - {1'b0, q_q});
    end
    if (state_q == ST_MUL2) begin
      p2_q <= gstart_q[trk_q] * q_q;
    end
    if (state_q == ST_OUT && out_free) begin
      odata_q <= {7'd0, cphr_q[trk_q], cstep_q[trk_q], psum[30:16],
                  (gaterem_q[trk_q] != 12'd0), trk_q};
      olast_q <= (trk_q == TRK_W'(TRACKS - 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_q   <= '0;
      octave_q  <= '0;
      gatelen_q <= 13'd48;
      for (int i = 0; i < 3; i++) begin
        glen_q[i] <= 16'd1;
      end
      for (int i = 0; i < TRACKS * PHRASES; i++) begin
        slim_q[i] <= STP_W'(3);
      end
      for (int i = 0; i < TRACKS; i++) begin
        plim_q[i]    <= PHR_W'(3);
        cstep_q[i]   <= '0;
        cphr_q[i]    <= '0;
        pendv_q[i]   <= 1'b0;
        pendp_q[i]   <= '0;
        gstart_q[i]  <= '0;
        gend_q[i]    <= '0;
        lpv_q[i]     <= 1'b0;
        grem_q[i]    <= '0;
        gaterem_q[i] <= '0;
      end
      rstpend_q <= 1'b0;
      usedrst_q <= 1'b0;
      state_q   <= ST_CLR;
      clr_q     <= '0;
      trk_q     <= '0;
      sedge_q   <= '0;
      conn_q    <= '0;
      pedge_q   <= '0;
      gphr_q    <= 1'b0;
      take_q    <= 1'b0;
      trig_q    <= 1'b0;
      q_q       <= '0;
      dcnt_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_PAUSE:  pause_q   <= pwdata[2:0];
          REG_OCTAVE: octave_q  <= pwdata[5:0];
          REG_GLIDE0: glen_q[0] <= pwdata[15:0];
          REG_GLIDE1: glen_q[1] <= pwdata[15:0];
          REG_GLIDE2: glen_q[2] <= pwdata[15:0];
          REG_GATE:   gatelen_q <= pwdata[12:0];
          default: ;
        endcase
      end
      if (state_q == ST_OUT && out_free) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + 9'd1;
          if (clr_q == 9'(MEM_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == REQ_LIMIT && s_axis_tdata[1:0] < 2'(TRACKS)) begin
              slim_q[{s_axis_tdata[1:0], s_axis_tdata[4:2]}] <= s_axis_tdata[19:16];
              plim_q[s_axis_tdata[1:0]] <= s_axis_tdata[22:20];
            end else if (s_axis_tuser == REQ_TICK) begin
              sedge_q <= s_axis_tdata[25:23];
              conn_q  <= s_axis_tdata[28:26];
              pedge_q <= s_axis_tdata[31:29];
              gphr_q  <= s_axis_tdata[32];
              if (s_axis_tdata[33]) begin
                rstpend_q <= 1'b1;
              end
              usedrst_q <= 1'b0;
              trk_q     <= '0;
              state_q   <= ST_EVAL;
            end
          end
        end
        ST_EVAL: begin
          trig_q <= 1'b0;
          if (t_clk && !t_paused) begin
            if (gphr_q || t_ped) begin
              pendv_q[trk_q] <= 1'b1;
              pendp_q[trk_q] <= nxt_phr;
            end
            if (t_sed) begin
              if (rstpend_q) begin
                usedrst_q <= 1'b1;
              end
              cstep_q[trk_q] <= nxt_step;
              take_q  <= (nxt_step == '0);
              state_q <= ST_RD1;
            end else begin
              state_q <= ST_GATE;
            end
          end else if (pendv_q[trk_q] && (pendp_q[trk_q] != cphr_q[trk_q])) begin
            pendv_q[trk_q] <= 1'b0;
            cphr_q[trk_q]  <= pendp_q[trk_q];
            state_q <= ST_RD2;
          end else begin
            pendv_q[trk_q] <= 1'b0;
            state_q <= ST_GATE;
          end
        end
        ST_RD1, ST_RD2: begin
          gstart_q[trk_q] <= lpv_q[trk_q] ? gend_q[trk_q] : target;
          lpv_q[trk_q]    <= 1'b1;
          gend_q[trk_q]   <= target;
          grem_q[trk_q]   <= glen_t;
          if (!rd_q[6]) begin
            trig_q <= 1'b1;
          end
          if (state_q == ST_RD1 && take_q && pendv_q[trk_q] &&
              (pendp_q[trk_q] != cphr_q[trk_q])) begin
            pendv_q[trk_q] <= 1'b0;
            cphr_q[trk_q]  <= pendp_q[trk_q];
            state_q <= ST_RD2;
          end else begin
            if (state_q == ST_RD1 && take_q) begin
              pendv_q[trk_q] <= 1'b0;
            end
            state_q <= ST_GATE;
          end
        end
        ST_GATE: begin
          gaterem_q[trk_q] <= (gate_load != 13'd0) ? 12'(gate_load - 13'd1) : 12'd0;
          grem_q[trk_q] <= grem_dec;
          dcnt_q <= '0;
          if (grem_dec == 16'd0) begin
            q_q     <= '0;
            state_q <= ST_MUL1;
          end else if (grem_dec >= glen_t) begin
            q_q     <= 16'hFFFF;
            state_q <= ST_MUL1;
          end else begin
            q_q     <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          q_q    <= {q_q[14:0], (div_sh >= {1'b0, divlen_q})};
          dcnt_q <= dcnt_q + 5'd1;
          if (dcnt_q == 5'd15) begin
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: state_q <= ST_MUL2;
        ST_MUL2: state_q <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            if (trk_q == TRK_W'(TRACKS - 1)) begin
              if (usedrst_q) begin
                rstpend_q <= 1'b0;
              end
              state_q <= ST_IDLE;
            end else begin
              trk_q   <= trk_q + 1'b1;
              state_q <= ST_EVAL;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: bench/three_track_phrase_step_sequencer_core_tb.sv
// Regression bench for the three-track phrase step sequencer core.
// Streams write and tick beats with random gaps and back-pressure, predicts every
// result beat from its own model of the tracks, and needs ttps_pkg and the core.
`timescale 1ns / 100ps
module three_track_phrase_step_sequencer_core_tb;
  import ttps_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 20000;
  localparam int unsigned SETTLE_CYC  = 200;
  localparam int unsigned HOLD_CYC    = 3000;

  typedef struct packed {
    logic [1:0]  trk;
    logic        gate;
    logic [14:0] pitch;
    logic [3:0]  step;
    logic [2:0]  phrase;
    logic        tlast;
  } track_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  three_track_phrase_step_sequencer_core DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Model state.
  logic [2:0]  pause_mask;
  logic [5:0]  octave_sel;
  logic [15:0] glide_len [3];
  logic [12:0] gate_len;
  logic [6:0]  note_mem [3][8][16];
  logic [3:0]  step_lim [3][8];
  logic [2:0]  phrase_lim [3];
  logic [3:0]  cur_step [3];
  logic [2:0]  cur_phrase [3];
  bit          pend_valid [3];
  logic [2:0]  pend_phrase [3];
  int unsigned glide_from [3], glide_to [3], glide_left [3], gate_left [3];
  bit          pitch_seen [3];
  bit          reset_armed;

  track_report_t report_q [$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned hold_requests = 0;
  int unsigned idle_cycles = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic int unsigned glide_samples(int t);
    int unsigned v = glide_len[t];
    if (v == 0) v = 1;
    if (v > GLIDE_MAX) v = GLIDE_MAX;
    return v;
  endfunction

  function automatic bit load_note(int t);
    logic [6:0] e = note_mem[t][cur_phrase[t]][cur_step[t]];
    int unsigned note = e[5:0];
    int unsigned oct = (octave_sel >> (2 * t)) & 3;
    int unsigned target;
    if (note > MAX_NOTE) note = 0;
    target = (note + 12 * oct) * 256;
    glide_from[t] = pitch_seen[t] ? glide_to[t] : target;
    pitch_seen[t] = 1'b1;
    glide_to[t] = target;
    glide_left[t] = glide_samples(t);
    return !e[6];
  endfunction

  function automatic bit take_phrase(int t);
    if (!pend_valid[t]) return 1'b0;
    pend_valid[t] = 1'b0;
    if (pend_phrase[t] == cur_phrase[t]) return 1'b0;
    cur_phrase[t] = pend_phrase[t];
    return load_note(t);
  endfunction

  function automatic void reset_model();
    pause_mask = '0;
    octave_sel = '0;
    foreach (glide_len[i]) glide_len[i] = 16'd1;
    gate_len = 13'd48;
    foreach (note_mem[i, j, k]) note_mem[i][j][k] = '0;
    foreach (step_lim[i, j]) step_lim[i][j] = 4'd3;
    for (int t = 0; t < 3; t++) begin
      phrase_lim[t] = 3'd3;
      cur_step[t] = '0;
      cur_phrase[t] = '0;
      pend_valid[t] = 1'b0;
      pend_phrase[t] = '0;
      glide_from[t] = 0;
      glide_to[t] = 0;
      glide_left[t] = 0;
      gate_left[t] = 0;
      pitch_seen[t] = 1'b0;
    end
    reset_armed = 1'b0;
  endfunction

  function automatic void sequence_beat(logic [1:0] req, logic [39:0] d);
    logic [1:0] trk = d[1:0];
    logic [2:0] phr = d[4:2];
    logic [2:0] sedge = d[25:23], conn = d[28:26], pedge = d[31:29];
    logic [1:0] gedge = d[33:32];
    bit used_reset = 1'b0;
    bit trig, paused, clocked;
    int unsigned nxt, gl, len, g, pitch;
    track_report_t r;
    if (req == REQ_STEP) begin
      if (trk < 3) note_mem[trk][phr][d[8:5]] = {d[15], d[14:9]};
      return;
    end
    if (req == REQ_LIMIT) begin
      if (trk < 3) begin
        step_lim[trk][phr] = d[19:16];
        phrase_lim[trk] = d[22:20];
      end
      return;
    end
    if (req != REQ_TICK) return;
    if (gedge[1]) reset_armed = 1'b1;
    for (int t = 0; t < 3; t++) begin
      paused = pause_mask[t];
      clocked = conn[t];
      trig = 1'b0;
      if ((gedge[0] || pedge[t]) && !paused && clocked) begin
        nxt = (cur_phrase[t] + 1) % PHRASES;
        if (nxt > phrase_lim[t]) nxt = 0;
        pend_valid[t] = 1'b1;
        pend_phrase[t] = 3'(nxt);
      end
      if (clocked && !paused) begin
        if (sedge[t]) begin
          if (reset_armed) begin
            used_reset = 1'b1;
            nxt = 0;
          end else if (cur_step[t] >= step_lim[t][cur_phrase[t]]) begin
            nxt = 0;
          end else begin
            nxt = cur_step[t] + 1;
          end
          cur_step[t] = 4'(nxt);
          trig = load_note(t);
          if (nxt == 0 && take_phrase(t)) trig = 1'b1;
        end
      end else if (take_phrase(t)) begin
        trig = 1'b1;
      end
      gl = gate_len;
      if (gl == 0) gl = 1;
      if (gl > GATE_MAX) gl = GATE_MAX;
      if (trig && gate_left[t] < gl) gate_left[t] = gl;
      if (gate_left[t] > 0) gate_left[t]--;
      if (glide_left[t] > 0) glide_left[t]--;
      len = glide_samples(t);
      g = (glide_left[t] == 0) ? 0 : 32'((glide_left[t] * 64'd65536) / len);
      if (g > 32'hFFFF) g = 32'hFFFF;
      pitch = 32'((64'(glide_to[t]) * (65536 - g) + 64'(glide_from[t]) * g + 32768) >> 16);
      r.trk = 2'(t);
      r.gate = gate_left[t] > 0;
      r.pitch = pitch[14:0];
      r.step = cur_step[t];
      r.phrase = cur_phrase[t];
      r.tlast = (t == 2);
      report_q.push_back(r);
    end
    if (used_reset) reset_armed = 1'b0;
  endfunction

  task automatic send_beat(logic [1:0] req, logic [39:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sequence_beat(req, d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PAUSE:  pause_mask = value[2:0];
      REG_OCTAVE: octave_sel = value[5:0];
      REG_GLIDE0: glide_len[0] = value[15:0];
      REG_GLIDE1: glide_len[1] = value[15:0];
      REG_GLIDE2: glide_len[2] = value[15:0];
      REG_GATE:   gate_len = value[12:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  function automatic logic [39:0] pack_fields(logic [1:0] trk, logic [2:0] phr,
      logic [3:0] pat, logic [5:0] note, logic trg, logic [3:0] sc, logic [2:0] pc,
      logic [2:0] sedge, logic [2:0] conn, logic [2:0] pedge, logic [1:0] gedge);
    return {6'd0, gedge, pedge, conn, sedge, pc, sc, trg, note, pat, phr, trk};
  endfunction

  function automatic logic [39:0] tick_fields(logic [2:0] sedge, logic [2:0] conn,
      logic [2:0] pedge, logic [1:0] gedge);
    return pack_fields(0, 0, 0, 0, 0, 0, 0, sedge, conn, pedge, gedge);
  endfunction

  function automatic logic [39:0] random_tick();
    logic [2:0] conn = ($urandom_range(0, 4) != 0) ? 3'b111 : 3'($urandom);
    logic [2:0] pedge = ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'b000;
    logic [1:0] gedge = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'b00;
    return tick_fields(3'($urandom), conn, pedge, gedge);
  endfunction

  task automatic send_random(int unsigned count);
    logic [1:0] req;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: req = REQ_STEP;
        3:       req = REQ_LIMIT;
        4:       req = 2'($urandom);
        default: req = REQ_TICK;
      endcase
      if (req == REQ_TICK) send_beat(req, random_tick());
      else send_beat(req, {6'd0, 34'($urandom) | (34'($urandom) << 32)}
                     & 40'h00_FFFF_FFFF | 40'(($urandom & 3)) << 32);
    end
  endtask

  task automatic test_directed_writes();
    send_beat(REQ_STEP, pack_fields(0, 0, 0, 6'd36, 0, 0, 0, 0, 0, 0, 0));
    send_beat(REQ_STEP, pack_fields(0, 0, 1, 6'd63, 0, 0, 0, 0, 0, 0, 0));
    send_beat(REQ_STEP, pack_fields(1, 7, 15, 6'd12, 1, 0, 0, 0, 0, 0, 0));
    send_beat(REQ_STEP, pack_fields(2, 1, 0, 6'd24, 0, 0, 0, 0, 0, 0, 0));
    send_beat(REQ_STEP, pack_fields(3, 0, 2, 6'd5, 0, 0, 0, 0, 0, 0, 0));
    send_beat(REQ_LIMIT, pack_fields(1, 7, 0, 0, 0, 4'd15, 3'd7, 0, 0, 0, 0));
    send_beat(REQ_LIMIT, pack_fields(2, 0, 0, 0, 0, 4'd0, 3'd1, 0, 0, 0, 0));
    send_beat(REQ_LIMIT, pack_fields(3, 2, 0, 0, 0, 4'd1, 3'd0, 0, 0, 0, 0));
    send_beat(2'd3, 40'hFF_FFFF_FFFF);
  endtask

  task automatic test_directed_ticks();
    send_beat(REQ_TICK, tick_fields(3'b000, 3'b000, 3'b000, 2'b00));
    send_beat(REQ_TICK, tick_fields(3'b111, 3'b111, 3'b000, 2'b00));
    send_beat(REQ_TICK, tick_fields(3'b111, 3'b111, 3'b000, 2'b00));
    send_beat(REQ_TICK, tick_fields(3'b000, 3'b111, 3'b111, 2'b00));
    for (int i = 0; i < 4; i++) send_beat(REQ_TICK, tick_fields(3'b111, 3'b111, 0, 0));
    send_beat(REQ_TICK, tick_fields(3'b000, 3'b111, 3'b000, 2'b01));
    send_beat(REQ_TICK, tick_fields(3'b000, 3'b000, 3'b000, 2'b00));
    send_beat(REQ_TICK, tick_fields(3'b000, 3'b111, 3'b000, 2'b10));
    send_beat(REQ_TICK, tick_fields(3'b111, 3'b111, 3'b000, 2'b00));
    send_beat(REQ_TICK, tick_fields(3'b111, 3'b111, 3'b111, 2'b11));
    send_beat(REQ_TICK, tick_fields(3'b101, 3'b011, 3'b110, 2'b00));
    wait_drained();
  endtask

  task automatic test_register_phase(logic [2:0] pm, logic [5:0] oct, logic [15:0] g0,
      logic [15:0] g1, logic [15:0] g2, logic [12:0] gt, int unsigned count);
    write_reg(REG_PAUSE, pm);
    write_reg(REG_OCTAVE, oct);
    write_reg(REG_GLIDE0, g0);
    write_reg(REG_GLIDE1, g1);
    write_reg(REG_GLIDE2, g2);
    write_reg(REG_GATE, gt);
    send_random(count);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_requests++;
    for (int i = 0; i < 30; i++) send_beat(REQ_TICK, random_tick());
    wait_drained();
  endtask

  // Receiver: long hold on request, otherwise a randomly chosen stall pattern.
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_cnt = 0;
  always @(posedge clk_i) begin
    if (holds_done != hold_requests) begin
      holds_done <= hold_requests;
      hold_left <= HOLD_CYC;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      mode_cnt <= mode_cnt + 1;
      if (mode_cnt % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (mode_cnt % 4 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    track_report_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[17:3],
             m_axis_tdata[21:18], m_axis_tdata[24:22], m_axis_tlast};
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = report_q.pop_front();
        if (got !== want || m_axis_tdata[31:25] !== '0) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("three_track_phrase_step_sequencer_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_writes();
    test_directed_ticks();
    test_register_phase(3'b000, 6'd0, 16'd1, 16'd4, 16'd9, 13'd48, 60);
    test_register_phase(3'b111, 6'd63, 16'd0, 16'd32768, 16'd65535, 13'd0, 40);
    test_register_phase(3'b010, 6'b100111, 16'd3, 16'd7, 16'd32768, 13'd8191, 50);
    test_register_phase(3'b101, 6'b011000, 16'd2, 16'd1, 16'd5, 13'd4096, 40);
    test_backpressure();
    test_register_phase(3'b000, 6'b110110, 16'd6, 16'd2, 16'd1, 13'd1, 60);
    test_register_phase(3'($urandom), 6'($urandom), 16'($urandom_range(1, 40)),
                        16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                        13'($urandom_range(1, 60)), 60);
    if (mismatches == 0) begin
      $display("three_track_phrase_step_sequencer_core regression: pass");
    end else begin
      $display("three_track_phrase_step_sequencer_core regression: fail");
    end
    $finish;
  end

endmodule
